### rtl/core/zsa_pkg.sv
package zsa_pkg;

  localparam int MeanW    = 48;          // running mean, sample units plus extra fraction
  localparam int DevW     = MeanW + 1;   // signed difference of two means, or its magnitude
  localparam int SumW     = 64;          // sum of squared deviations
  localparam int ThrW     = 16;          // threshold, unsigned Q8.8
  localparam int TsqW     = 2 * ThrW;    // threshold squared, Q16.16
  localparam int VarShift = 16;          // fraction bits of the squared threshold

  localparam logic [ThrW-1:0] ThrReset = 16'd768;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } zsa_sts_t;

endpackage

### rtl/core/zsa_div.sv
module zsa_div import zsa_pkg::*; #(
  parameter int DvdW = 49,
  parameter int DsrW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic [DvdW-1:0] quotient_o,
  output zsa_sts_t        sts_o
);

  localparam int CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] CntLast = CntW'(DvdW - 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW:0]   trial;
  logic [DsrW:0]   diff;
  logic            ge;

  // restoring division, one quotient bit a cycle; quotient bits shift into the dividend
  always_comb begin
    trial  = {rem_q, dvd_q[DvdW-1]};
    diff   = trial - {1'b0, dsr_q};
    ge     = (trial >= {1'b0, dsr_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DsrW-1:0] : trial[DsrW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dvd_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && (cnt_q == CntLast);

endmodule

### rtl/core/zsa_mul.sv
module zsa_mul import zsa_pkg::*; #(
  parameter int AW = 49,
  parameter int BW = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] product_o,
  output zsa_sts_t         sts_o
);

  localparam int CntW = $clog2(BW);
  localparam logic [CntW-1:0] CntLast = CntW'(BW - 1);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]    a_q, a_d;
  logic [AW+BW-1:0] acc_q, acc_d;
  logic [AW:0]      psum;

  // shift-add: multiplier bits leave at the bottom, partial sum enters at the top
  always_comb begin
    psum   = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : '0);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      acc_d  = (AW+BW)'(b_i);
    end else if (busy_q) begin
      acc_d = {psum, acc_q[BW-1:1]};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign product_o  = acc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && (cnt_q == CntLast);

endmodule

### rtl/core/streaming_zscore_anomaly_flag.sv
// Streaming z-score anomaly flag over a running (Welford) mean and variance.
// Input channel in_valid_i/in_ready_o carries one sample with its null flag;
// output channel out_valid_o/out_ready_i carries one outlier bit per item.
// Every input item gives exactly one result item, in order.
// A null item leaves the statistics alone and goes straight to the done state,
// which yields 0. A valid sample runs through a bit-serial divider for the mean
// step, two bit-serial multipliers in parallel for the deviation products,
// then two more in parallel for the squared z-score compare. One item is in
// work at a time; in_ready_o is high whenever the datapath is free, even while
// a finished result still sits in the output register.
// If the receiver stalls, the finished flag waits in the block until the
// output register drains, and no further item is taken meanwhile.
// Reset clears count, mean and sum of squares and sets z_threshold to 3.0.
// cfg_we_i writes z_threshold (unsigned Q8.8); write it only when
// the block is idle.
module streaming_zscore_anomaly_flag import zsa_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic        [ThrW-1:0]         cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           sample_null_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           outlier_o
);

  localparam int MeanShift = MeanW - SAMPLE_WIDTH;
  localparam int SqW       = 2 * DevW;
  localparam int VarW      = SqW + COUNT_WIDTH;
  localparam int ThrPW     = SumW + TsqW;
  localparam int LhsW      = VarW + VarShift;
  localparam int RhsW      = ThrPW + 2 * MeanShift;
  localparam int CmpW      = (LhsW > RhsW) ? LhsW : RhsW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_MEAN = 4'd3;
  localparam logic [3:0] S_M1GO = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_M2GO = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]             state_q, state_d;
  logic [ThrW-1:0]        thr_q, thr_d;
  logic [TsqW-1:0]        tsq_q, tsq_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [MeanW-1:0]       mean_q, mean_d;
  logic [SumW-1:0]        m2_q, m2_d;
  logic [MeanW-1:0]       xs_q, xs_d;
  logic                   neg_q, neg_d;
  logic [DevW-1:0]        ad_q, ad_d;
  logic [DevW-1:0]        d2m_q, d2m_d;
  logic                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic                   flag_q, flag_d;

  logic                   accept;
  logic [MeanW-1:0]       xs_in;
  logic [DevW-1:0]        delta_in;
  logic [DevW-1:0]        nm_full;
  logic [DevW-1:0]        d2;
  logic [SqW-1:0]         dev_sh;
  logic [SumW:0]          sum_ext;
  logic                   sum_big;
  logic [CmpW-1:0]        lhs;
  logic [CmpW-1:0]        rhs;
  logic                   has_var;

  logic                   div_start, m1_start, m2_start;
  logic [DevW-1:0]        quo;
  logic [SqW-1:0]         dev_p, sq_p;
  logic [VarW-1:0]        var_p;
  logic [ThrPW-1:0]       thr_p;
  zsa_sts_t               div_sts, dev_sts, sq_sts, var_sts, thr_sts;

  assign accept    = in_valid_i && in_ready_o;
  assign div_start = (state_q == S_PREP);
  assign m1_start  = (state_q == S_M1GO);
  assign m2_start  = (state_q == S_M2GO);

  zsa_div #(
    .DvdW(DevW),
    .DsrW(COUNT_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(ad_q),
    .divisor_i (count_q),
    .quotient_o(quo),
    .sts_o     (div_sts)
  );

  zsa_mul #(
    .AW(DevW),
    .BW(DevW)
  ) u_mul_dev (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (m1_start),
    .a_i      (ad_q),
    .b_i      (d2m_q),
    .product_o(dev_p),
    .sts_o    (dev_sts)
  );

  zsa_mul #(
    .AW(DevW),
    .BW(DevW)
  ) u_mul_sq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (m1_start),
    .a_i      (d2m_q),
    .b_i      (d2m_q),
    .product_o(sq_p),
    .sts_o    (sq_sts)
  );

  zsa_mul #(
    .AW(SqW),
    .BW(COUNT_WIDTH)
  ) u_mul_var (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (m2_start),
    .a_i      (sq_p),
    .b_i      (count_q - COUNT_WIDTH'(1)),
    .product_o(var_p),
    .sts_o    (var_sts)
  );

  zsa_mul #(
    .AW(SumW),
    .BW(TsqW)
  ) u_mul_thr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (m2_start),
    .a_i      (m2_q),
    .b_i      (tsq_q),
    .product_o(thr_p),
    .sts_o    (thr_sts)
  );

  always_comb begin
    xs_in    = MeanW'(sample_i) << MeanShift;
    delta_in = {xs_in[MeanW-1], xs_in} - {mean_q[MeanW-1], mean_q};

    // truncated step keeps the new mean between old mean and sample
    nm_full = neg_q ? ({mean_q[MeanW-1], mean_q} - quo) : ({mean_q[MeanW-1], mean_q} + quo);
    d2      = {xs_q[MeanW-1], xs_q} - {nm_full[MeanW-1], nm_full[MeanW-1:0]};

    dev_sh  = dev_p >> (2 * MeanShift);
    sum_big = |dev_sh[SqW-1:SumW];
    sum_ext = {1'b0, m2_q} + {1'b0, dev_sh[SumW-1:0]};

    // squared z-score compare, both sides brought to a common scale
    lhs     = CmpW'(var_p) << VarShift;
    rhs     = CmpW'(thr_p) << (2 * MeanShift);
    has_var = (count_q > COUNT_WIDTH'(1)) && (m2_q != '0);
  end

  always_comb begin
    state_d     = state_q;
    thr_d       = cfg_we_i ? cfg_wdata_i : thr_q;
    tsq_d       = TsqW'(thr_q) * TsqW'(thr_q);
    count_d     = count_q;
    mean_d      = mean_q;
    m2_d        = m2_q;
    xs_d        = xs_q;
    neg_d       = neg_q;
    ad_d        = ad_q;
    d2m_d       = d2m_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    flag_d      = flag_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sample_null_i) begin
            res_d   = 1'b0;
            state_d = S_DONE;
          end else begin
            xs_d    = xs_in;
            neg_d   = delta_in[DevW-1];
            ad_d    = delta_in[DevW-1] ? (~delta_in + DevW'(1)) : delta_in;
            if (count_q != '1) begin
              count_d = count_q + COUNT_WIDTH'(1);
            end
            state_d = S_PREP;
          end
        end
      end
      S_PREP: state_d = S_DIV;
      S_DIV: begin
        if (div_sts.done) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        mean_d  = nm_full[MeanW-1:0];
        d2m_d   = d2[DevW-1] ? (~d2 + DevW'(1)) : d2;
        state_d = S_M1GO;
      end
      S_M1GO: state_d = S_M1;
      S_M1: begin
        if (dev_sts.done && sq_sts.done) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        m2_d    = (sum_big || sum_ext[SumW]) ? '1 : sum_ext[SumW-1:0];
        state_d = S_M2GO;
      end
      S_M2GO: state_d = S_M2;
      S_M2: begin
        if (!var_sts.busy && !thr_sts.busy) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        res_d   = has_var && (lhs > rhs);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          flag_d      = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= ThrReset;
      count_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      count_q     <= count_d;
      mean_q      <= mean_d;
      m2_q        <= m2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tsq_q  <= tsq_d;
    xs_q   <= xs_d;
    neg_q  <= neg_d;
    ad_q   <= ad_d;
    d2m_q  <= d2m_d;
    res_q  <= res_d;
    flag_q <= flag_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign outlier_o   = flag_q;

endmodule
